@@ rtl/core/ple_pkg.sv @@
// ----------------------------------------------------------------------------
// ple_pkg
// Shared types and constants of the positional list engine.
// ----------------------------------------------------------------------------
package ple_pkg;

  // Operation codes carried by an input item
  typedef enum logic [2:0] {
    OP_INSERT = 3'd0,
    OP_DELETE = 3'd1,
    OP_GET    = 3'd2,
    OP_LOCATE = 3'd3,
    OP_CLEAR  = 3'd4
  } op_t;

  // What every cell of the chain does in a cycle
  typedef enum logic [1:0] {
    CELL_HOLD   = 2'd0,
    CELL_ROTATE = 2'd1,
    CELL_INSERT = 2'd2,
    CELL_DELETE = 2'd3
  } cell_cmd_t;

  typedef struct packed {
    cell_cmd_t  cmd;
    logic [5:0] position;
  } cell_ctl_t;

  // Width that holds any cell index plus one for the largest capacity
  localparam int IDX_W = 11;

  localparam int POS_W  = 6;
  localparam int VAL_W  = 32;

endpackage

@@ rtl/core/ple_if.sv @@
// ----------------------------------------------------------------------------
// ple_in_if / ple_out_if
// Valid/ready channels for list operations and their results.
// ----------------------------------------------------------------------------
interface ple_in_if;
  logic               valid;
  logic               ready;
  logic [2:0]         op;
  logic [5:0]         position;
  logic signed [31:0] value;

  modport source (output valid, output op, output position, output value, input ready);
  modport sink   (input valid, input op, input position, input value, output ready);
endinterface

interface ple_out_if;
  logic               valid;
  logic               ready;
  logic               status;
  logic signed [31:0] data_out;
  logic [5:0]         found_position;
  logic [5:0]         length;
  logic               is_empty;

  modport source (output valid, output status, output data_out, output found_position,
                  output length, output is_empty, input ready);
  modport sink   (input valid, input status, input data_out, input found_position,
                  input length, input is_empty, output ready);
endinterface

@@ rtl/core/ple_cell.sv @@
// ----------------------------------------------------------------------------
// ple_cell
// One list slot: holds an entry and trades it with its neighbors.
// ----------------------------------------------------------------------------
module ple_cell
  import ple_pkg::*;
#(
  parameter int DATA_WIDTH = 32,
  parameter int IDX        = 0
) (
  input  logic                  clk,
  input  cell_ctl_t             ctl,
  input  logic [DATA_WIDTH-1:0] ins_val,
  input  logic [DATA_WIDTH-1:0] left_d,
  input  logic [DATA_WIDTH-1:0] right_d,
  output logic [DATA_WIDTH-1:0] q
);

  localparam logic [IDX_W-1:0] SLOT     = IDX_W'(IDX);
  localparam logic [IDX_W-1:0] SLOT_POS = IDX_W'(IDX + 1);

  logic [DATA_WIDTH-1:0] q_r;
  logic [DATA_WIDTH-1:0] q_nxt;
  logic [IDX_W-1:0]      pos_w;

  assign pos_w = IDX_W'(ctl.position);

  always_comb begin
    q_nxt = q_r;
    case (ctl.cmd)
      CELL_ROTATE: q_nxt = right_d;
      CELL_INSERT: begin
        if (SLOT >= pos_w) begin
          q_nxt = left_d;
        end else if (SLOT_POS == pos_w) begin
          q_nxt = ins_val;
        end
      end
      // slots at or past the removed one pull from the right
      CELL_DELETE: begin
        if (SLOT_POS >= pos_w) begin
          q_nxt = right_d;
        end
      end
      default: q_nxt = q_r;
    endcase
  end

  always_ff @(posedge clk) begin
    q_r <= q_nxt;
  end

  assign q = q_r;

endmodule

@@ rtl/core/positional_list_engine.sv @@
// ----------------------------------------------------------------------------
// positional_list_engine
// Fixed-capacity ordered list kept packed in a chain of register cells.
// ----------------------------------------------------------------------------
// One item is handled at a time. Insert, clear, any rejected item and a locate
// on an empty list go from idle straight to the finish step, which loads the
// output register, and the input is ready again as the result enters it. Get,
// delete and locate on a non-empty list first pass through the scan step, in
// which the cell chain rotates the whole list once past cell 0, where the
// entry is read or compared, and ends back in place; delete then closes the
// gap in one parallel shift. A new item is accepted while the previous result
// still waits in the output register; the engine then holds in its last step,
// with the input stalled, until that result is taken.
module positional_list_engine
  import ple_pkg::*;
#(
  parameter int CAPACITY   = 32,
  parameter int DATA_WIDTH = 32
) (
  input  logic      clk,
  input  logic      rst_n,
  ple_in_if.sink    in_ch,
  ple_out_if.source out_ch
);

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int KW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam logic [IDX_W-1:0] CAP_W  = IDX_W'(CAPACITY);
  localparam logic [KW-1:0]    K_LAST = KW'(CAPACITY - 1);

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_SCAN   = 3'b010,
    ST_FINISH = 3'b100
  } state_t;

  state_t state_r, state_nxt;

  logic [CW-1:0]         count_r, count_nxt;
  logic [KW-1:0]         k_r, k_nxt;
  op_t                   op_r;
  logic [POS_W-1:0]      pos_r;
  logic [DATA_WIDTH-1:0] val_r;
  logic                  err_r;
  logic [DATA_WIDTH-1:0] data_r;
  logic [CW-1:0]         found_r;
  logic                  hit_r;

  logic                  out_valid_r;
  logic                  status_r;
  logic signed [31:0]    data_out_r;
  logic [5:0]            found_out_r;
  logic [5:0]            length_r;
  logic                  empty_r;

  logic [DATA_WIDTH-1:0] cell_q [CAPACITY];
  cell_ctl_t             ctl;

  logic                  accept;
  logic                  out_free;
  logic                  in_err;
  logic                  in_scan;
  logic [IDX_W-1:0]      in_pos_w;
  logic [IDX_W-1:0]      cnt_w;
  logic [IDX_W-1:0]      k_w;
  logic [IDX_W-1:0]      pos_w;
  logic signed [63:0]    in_val_x;
  logic signed [63:0]    data_x;
  logic [63:0]           count_x;
  logic [63:0]           found_x;

  assign accept   = in_ch.valid && in_ch.ready;
  assign out_free = !out_valid_r || out_ch.ready;
  assign in_ch.ready = (state_r == ST_IDLE);

  assign in_pos_w = IDX_W'(in_ch.position);
  assign cnt_w    = IDX_W'(count_r);
  assign k_w      = IDX_W'(k_r);
  assign pos_w    = IDX_W'(pos_r);
  assign in_val_x = 64'(in_ch.value);

  // check the item against the current length
  always_comb begin
    in_err  = 1'b1;
    in_scan = 1'b0;
    case (op_t'(in_ch.op))
      OP_INSERT: in_err = !(cnt_w < CAP_W && in_pos_w != '0 && in_pos_w <= cnt_w + 1'b1);
      OP_DELETE, OP_GET: begin
        in_err  = !(in_pos_w != '0 && in_pos_w <= cnt_w);
        in_scan = !in_err;
      end
      OP_LOCATE: begin
        in_err  = 1'b0;
        in_scan = (count_r != '0);
      end
      OP_CLEAR: in_err = 1'b0;
      default:  in_err = 1'b1;
    endcase
  end

  always_comb begin
    state_nxt    = state_r;
    k_nxt        = k_r;
    count_nxt    = count_r;
    ctl.cmd      = CELL_HOLD;
    ctl.position = pos_r;
    case (state_r)
      ST_IDLE: begin
        k_nxt = '0;
        if (accept) begin
          state_nxt = in_scan ? ST_SCAN : ST_FINISH;
        end
      end
      ST_SCAN: begin
        ctl.cmd = CELL_ROTATE;
        k_nxt   = k_r + 1'b1;
        if (k_r == K_LAST) begin
          state_nxt = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
          if (!err_r) begin
            case (op_r)
              OP_INSERT: begin
                ctl.cmd   = CELL_INSERT;
                count_nxt = count_r + 1'b1;
              end
              OP_DELETE: begin
                ctl.cmd   = CELL_DELETE;
                count_nxt = count_r - 1'b1;
              end
              OP_CLEAR: count_nxt = '0;
              default:  count_nxt = count_r;
            endcase
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  genvar gi;
  generate
    for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
      ple_cell #(
        .DATA_WIDTH (DATA_WIDTH),
        .IDX        (gi)
      ) u_cell (
        .clk     (clk),
        .ctl     (ctl),
        .ins_val (val_r),
        .left_d  (cell_q[(gi + CAPACITY - 1) % CAPACITY]),
        .right_d (cell_q[(gi + 1) % CAPACITY]),
        .q       (cell_q[gi])
      );
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
      k_r         <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      k_r     <= k_nxt;
      if (state_r == ST_FINISH && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // item and scan results
  always_ff @(posedge clk) begin
    if (accept) begin
      op_r    <= op_t'(in_ch.op);
      pos_r   <= in_ch.position;
      val_r   <= in_val_x[DATA_WIDTH-1:0];
      err_r   <= in_err;
      data_r  <= '0;
      found_r <= '0;
      hit_r   <= 1'b0;
    end else if (state_r == ST_SCAN) begin
      // cell 0 shows entry k in this cycle
      if (op_r != OP_LOCATE && k_w + 1'b1 == pos_w) begin
        data_r <= cell_q[0];
      end
      if (op_r == OP_LOCATE && !hit_r && k_w < cnt_w && cell_q[0] == val_r) begin
        found_r <= CW'(k_r) + 1'b1;
        hit_r   <= 1'b1;
      end
    end
  end

  assign data_x  = 64'(signed'(data_r));
  assign count_x = 64'(count_nxt);
  assign found_x = 64'(found_r);

  always_ff @(posedge clk) begin
    if (state_r == ST_FINISH && out_free) begin
      status_r    <= err_r;
      data_out_r  <= data_x[31:0];
      found_out_r <= found_x[5:0];
      length_r    <= count_x[5:0];
      empty_r     <= (count_nxt == '0);
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.status         = status_r;
  assign out_ch.data_out       = data_out_r;
  assign out_ch.found_position = found_out_r;
  assign out_ch.length         = length_r;
  assign out_ch.is_empty       = empty_r;

endmodule
